// ----- rtl/potq_pkg.sv -----
// ----------------------------------------------------------------------------
// potq_pkg
// Shared types and result codes for the priority-ordered task queue.
// ----------------------------------------------------------------------------
package potq_pkg;

  // One queued transfer task descriptor
  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] byte_count;
    logic [7:0] handle;
    logic [3:0] slave;
    logic [7:0] options;
  } entry_t;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins_en;   // commit an insert this cycle
    logic pop_en;   // commit a pop this cycle
  } cell_ctrl_t;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_TOO_BIG  = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW = 3'd3;
  localparam logic [2:0] STAT_EMPTY    = 3'd4;

  // Request kinds carried on the input side-band
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

endpackage

// ----- rtl/priority_ordered_task_queue.sv -----
// ----------------------------------------------------------------------------
// priority_ordered_task_queue
// Bounded queue of transfer task descriptors kept sorted by priority.
// ----------------------------------------------------------------------------
// A request is captured in ST_IDLE, and in ST_CALC a row of QUEUE_DEPTH
// cells compares the new priority against every rank at once and shifts in
// a single step (back by one for an insert, forward by one for a pop).
// Only one request is in flight at a time. A new request is taken while
// the previous result still waits in the output register; the commit step
// holds until that register is free. Inserts land behind all tasks of
// equal or higher priority; an insert longer than MAX_TASK_BYTES or into a
// full queue leaves the queue unchanged. Every request returns exactly one
// result.
// ----------------------------------------------------------------------------
module priority_ordered_task_queue #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int MAX_TASK_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  // task_priority[7:0], byte_count[15:8], data_handle[23:16],
  // slave_id[27:24], option_bits[35:28], zero pad[39:36]
  input  logic [39:0] s_tdata,
  // req_type[0]
  input  logic [0:0]  s_tuser,
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], slot_index[6:3], out_priority[14:7], out_byte_count[22:15],
  // out_data_handle[30:23], out_slave_id[34:31], out_option_bits[42:35],
  // queue_count[47:43]
  output logic [47:0] m_tdata
);
  import potq_pkg::*;

  localparam int OccW = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t          state;
  logic            req_pop;
  entry_t          req_entry;
  logic [OccW-1:0] occ;
  logic [OccW-1:0] occ_next;

  cell_ctrl_t      ctrl;
  entry_t          entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ins_vec;
  logic [QUEUE_DEPTH-1:0] occupied;

  logic            commit;
  logic            too_big;
  logic            is_full;
  logic            queue_empty;
  logic [IdxW-1:0] slot_pos;
  logic [31:0]     slot_wide;
  logic [31:0]     count_wide;
  logic [2:0]      res_status;
  entry_t          res_entry;
  logic [3:0]      res_slot;

  // Accept a request whenever no other is in flight
  assign s_tready = (state == ST_IDLE);
  // Commit once the output register can take the result
  assign commit   = (state == ST_CALC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (s_tvalid) state <= ST_CALC;
        ST_CALC: if (commit)   state <= ST_IDLE;
        default:               state <= ST_IDLE;
      endcase
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_pop              <= (s_tuser[0] == REQ_POP);
      req_entry.prio       <= s_tdata[7:0];
      req_entry.byte_count <= s_tdata[15:8];
      req_entry.handle     <= s_tdata[23:16];
      req_entry.slave      <= s_tdata[27:24];
      req_entry.options    <= s_tdata[35:28];
    end
  end

  assign too_big     = (32'(req_entry.byte_count) > MAX_TASK_BYTES);
  assign is_full     = (32'(occ) >= QUEUE_DEPTH);
  assign queue_empty = (occ == '0);

  assign ctrl.ins_en = commit && !req_pop && !too_big && !is_full;
  assign ctrl.pop_en = commit && req_pop && !queue_empty;

  // Row of cells: rank 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (OccW'(i) < occ);

    potq_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied[i]),
      .prev_ins   ((i == 0) ? 1'b0 : ins_vec[(i == 0) ? 0 : i - 1]),
      .new_entry  (req_entry),
      .prev_entry (entries[(i == 0) ? 0 : i - 1]),
      .next_entry (entries[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .entry      (entries[i]),
      .ins        (ins_vec[i])
    );
  end

  // Landing rank of the new task: the first cell that takes it
  always_comb begin
    slot_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ins_vec[i] && (i == 0 || !ins_vec[(i == 0) ? 0 : i - 1])) begin
        slot_pos = slot_pos | IdxW'(i);
      end
    end
  end

  always_comb begin
    occ_next = occ;
    if (ctrl.ins_en) begin
      occ_next = occ + OccW'(1);
    end else if (ctrl.pop_en) begin
      occ_next = occ - OccW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // Build the result word
  assign slot_wide  = 32'(slot_pos);
  assign count_wide = 32'(occ_next);

  always_comb begin
    res_status = STAT_OK;
    res_slot   = '0;
    res_entry  = '0;
    if (!req_pop) begin
      if (too_big) begin
        res_status = STAT_TOO_BIG;
      end else if (is_full) begin
        res_status = STAT_OVERFLOW;
      end else begin
        res_slot   = slot_wide[3:0];
        res_status = (32'(occ_next) == QUEUE_DEPTH) ? STAT_FULL : STAT_OK;
      end
    end else if (queue_empty) begin
      res_status = STAT_EMPTY;
    end else begin
      res_entry = entries[0];
    end
  end

  // Output register: hold until the result transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {count_wide[4:0], res_entry.options, res_entry.slave,
                  res_entry.handle, res_entry.byte_count, res_entry.prio,
                  res_slot, res_status};
    end
  end

  // Occupancy never exceeds the number of cells
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= QUEUE_DEPTH)
    else $error("occupancy above queue depth");

  // A committed insert grows the queue by exactly one
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins_en |=> occ == $past(occ) + OccW'(1))
    else $error("insert did not grow occupancy");

  // A committed pop shrinks the queue by exactly one
  a_pop_shrink: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop_en |=> occ == $past(occ) - OccW'(1))
    else $error("pop did not shrink occupancy");

  // A new result only appears right after the commit step
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_CALC))
    else $error("result without commit");

endmodule

// ----- rtl/potq_cell.sv -----
// ----------------------------------------------------------------------------
// potq_cell
// One rank of the sorted queue: holds an entry, compares it against the
// incoming priority and takes the new entry or a neighbor's on commit.
// ----------------------------------------------------------------------------
module potq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                clk,
  input  potq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                prev_ins,
  input  potq_pkg::entry_t    new_entry,
  input  potq_pkg::entry_t    prev_entry,
  input  potq_pkg::entry_t    next_entry,
  output potq_pkg::entry_t    entry,
  output logic                ins
);
  import potq_pkg::*;

  logic first;

  // New task goes at or before this rank
  assign ins   = !occupied || (new_entry.prio > entry.prio);
  // This rank is where the new task lands
  assign first = ins && (IS_HEAD || !prev_ins);

  always_ff @(posedge clk) begin
    if (ctrl.ins_en && ins) begin
      entry <= first ? new_entry : prev_entry;
    end else if (ctrl.pop_en) begin
      entry <= next_entry;
    end
  end

endmodule

// ----- verif/priority_ordered_task_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ordered_task_queue_tb
// Stream-level check of the priority-ordered task queue.
// ----------------------------------------------------------------------------
// A short directed sequence walks the corners first. Empty pop, oversized
// inserts, ordering among equal priorities, a fill to the last slot, an
// insert into a full queue, and the length check ahead of the full check.
// About 1200 random requests follow. Their insert/pop mix shifts in blocks,
// so the queue sweeps between empty and full many times. A behavioral copy
// of the queue predicts every result. Each result transfer is compared field
// by field with the oldest prediction. Both stream sides idle at random,
// except during one long calm stretch.
// ----------------------------------------------------------------------------
module priority_ordered_task_queue_tb;
  import potq_pkg::*;

  localparam int DEPTH     = 16;
  localparam int MAX_BYTES = 64;
  localparam int RANDOM_REQUESTS = 1200;

  // Result layout, lowest field last so a cast from m_tdata lines up
  typedef struct packed {
    logic [4:0] count;
    logic [7:0] options;
    logic [3:0] slave;
    logic [7:0] handle;
    logic [7:0] bytes;
    logic [7:0] prio;
    logic [3:0] slot;
    logic [2:0] status;
  } result_t;

  typedef struct {
    logic    req;
    entry_t  job;
    bit      typed;   // use the hand-written result instead of the predictor's
    result_t want;
  } dir_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = REQ_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  // Behavioral queue: rank 0 is the head
  entry_t      model_ent [DEPTH];
  int unsigned model_held = 0;

  result_t  pending_results [$];
  dir_row_t dir_rows [$];
  int       mismatches = 0;
  bit       calm = 1'b0;   // no idling on either side while set

  priority_ordered_task_queue #(
    .QUEUE_DEPTH    (DEPTH),
    .MAX_TASK_BYTES (MAX_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the handshake locks up
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Four-state compare so an unknown bit on the bus counts as a mismatch
  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  // Apply one request to the behavioral queue and return its result.
  // Inserts land behind every rank of equal or higher priority.
  function automatic result_t queue_apply(logic req, entry_t job);
    result_t r;
    int      pos;
    r = '0;
    if (req == REQ_INSERT) begin
      if (job.byte_count > MAX_BYTES) begin
        r.status = STAT_TOO_BIG;
      end else if (model_held >= DEPTH) begin
        r.status = STAT_OVERFLOW;
      end else begin
        pos = model_held;
        for (int i = 0; i < model_held; i++) begin
          if (job.prio > model_ent[i].prio) begin
            pos = i;
            break;
          end
        end
        for (int i = model_held; i > pos; i--) model_ent[i] = model_ent[i - 1];
        model_ent[pos] = job;
        model_held++;
        r.slot   = pos[3:0];
        r.status = (model_held == DEPTH) ? STAT_FULL : STAT_OK;
      end
    end else begin
      if (model_held == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.prio    = model_ent[0].prio;
        r.bytes   = model_ent[0].byte_count;
        r.handle  = model_ent[0].handle;
        r.slave   = model_ent[0].slave;
        r.options = model_ent[0].options;
        for (int i = 0; i + 1 < model_held; i++) model_ent[i] = model_ent[i + 1];
        model_held--;
        r.status = STAT_OK;
      end
    end
    r.count = model_held[4:0];
    return r;
  endfunction

  function automatic entry_t mk_job(int prio, int bytes, int handle, int slave, int opts);
    entry_t e;
    e.prio       = prio[7:0];
    e.byte_count = bytes[7:0];
    e.handle     = handle[7:0];
    e.slave      = slave[3:0];
    e.options    = opts[7:0];
    return e;
  endfunction

  // Hand-written result with the pop fields left at zero
  function automatic result_t mk_want(logic [2:0] status, int slot, int count);
    result_t r;
    r        = '0;
    r.status = status;
    r.slot   = slot[3:0];
    r.count  = count[4:0];
    return r;
  endfunction

  task automatic add_row(logic req, entry_t job, bit typed, result_t want);
    dir_row_t row;
    row.req   = req;
    row.job   = job;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Drop valid for a random pause now and then, unless in the calm stretch
  task automatic pace_source();
    if (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Present one request, hold it until the transfer, then log its prediction
  task automatic submit(logic req, entry_t job, bit typed, result_t want);
    result_t predicted;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'b0, job.options, job.slave, job.handle, job.byte_count, job.prio};
    do @(posedge clk); while (!s_tready);
    predicted = queue_apply(req, job);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Sink side: stall with a probability of about 7 percent
  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
  end

  // Result monitor: compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", m_tdata));
      end else begin
        want = pending_results.pop_front();
        check_field("status",          got.status,  want.status);
        check_field("slot_index",      got.slot,    want.slot);
        check_field("out_priority",    got.prio,    want.prio);
        check_field("out_byte_count",  got.bytes,   want.bytes);
        check_field("out_data_handle", got.handle,  want.handle);
        check_field("out_slave_id",    got.slave,   want.slave);
        check_field("out_option_bits", got.options, want.options);
        check_field("queue_count",     got.count,   want.count);
      end
    end
  end

  initial begin
    int      bias;
    logic    req;
    int      prio;
    int      bytes;
    result_t none;
    none = '0;

    // Directed corners
    add_row(REQ_POP,    mk_job(0, 0, 0, 0, 0),               1, mk_want(STAT_EMPTY, 0, 0));
    add_row(REQ_INSERT, mk_job(9, 255, 0, 0, 0),             1, mk_want(STAT_TOO_BIG, 0, 0));
    add_row(REQ_INSERT, mk_job(9, MAX_BYTES + 1, 1, 2, 3),   1, mk_want(STAT_TOO_BIG, 0, 0));
    add_row(REQ_INSERT, mk_job(0, MAX_BYTES, 0, 0, 0),       1, mk_want(STAT_OK, 0, 1));
    add_row(REQ_INSERT, mk_job(255, 0, 255, 15, 255),        1, mk_want(STAT_OK, 0, 2));
    // equal priority goes behind the older task
    add_row(REQ_INSERT, mk_job(0, 1, 170, 5, 85),            1, mk_want(STAT_OK, 2, 3));
    add_row(REQ_INSERT, mk_job(128, 33, 85, 10, 170),        1, mk_want(STAT_OK, 1, 4));
    add_row(REQ_POP,    mk_job(0, 0, 0, 0, 0),               0, none);
    add_row(REQ_POP,    mk_job(0, 0, 0, 0, 0),               0, none);
    // fill to the last slot, mixing ties in; the final insert reports full
    for (int i = 0; i < DEPTH - 2; i++) begin
      add_row(REQ_INSERT, mk_job((i % 3 == 0) ? 7 : i * 19, i * 4, i, i, ~i), 0, none);
    end
    add_row(REQ_INSERT, mk_job(255, 0, 1, 1, 1),             1, mk_want(STAT_OVERFLOW, 0, DEPTH));
    // length check wins over the full check
    add_row(REQ_INSERT, mk_job(255, 200, 1, 1, 1),           1, mk_want(STAT_TOO_BIG, 0, DEPTH));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      pace_source();
      submit(dir_rows[k].req, dir_rows[k].job, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random traffic: the insert share changes every 40 requests so the
    // queue drains to empty and packs to full over and over
    bias = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 500 && n < 800);
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0: bias = 15;
          1: bias = 50;
          2: bias = 85;
          default: bias = 97;
        endcase
      end
      req = ($urandom_range(99) < bias) ? REQ_INSERT : REQ_POP;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: prio = $urandom_range(3);     // crowd ties
        5:             prio = $urandom_range(1) * 255;
        default:       prio = $urandom_range(255);
      endcase
      bytes = ($urandom_range(99) < 85) ? $urandom_range(MAX_BYTES)
                                        : $urandom_range(255, MAX_BYTES + 1);
      pace_source();
      submit(req, mk_job(prio, bytes, $urandom_range(255), $urandom_range(15),
                         $urandom_range(255)), 0, none);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    // Drain outstanding results before the final check
    for (int w = 0; w < 10000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
